// File: src/mpp_pkg.sv
// shared constants, action codes and controller/datapath interface types
// for the multichannel pwm port; no dependencies
package mpp_pkg;

    localparam int ACT_W      = 3;
    localparam int CH_FIELD_W = 5;
    localparam int VAL_W      = 24;
    localparam int RATE_W     = 24;
    localparam int PORT_W     = 32;
    localparam int FRAC_W     = 15;

    localparam int DEF_CHANNELS   = 32;
    localparam int DEF_COUNT_BITS = 24;

    localparam logic [RATE_W-1:0] RATE_RESET    = 24'd250000;
    localparam int                PERIOD_RESET  = 250;
    localparam logic [FRAC_W-1:0] FULL_DUTY     = 15'd25600;
    // 25600 = 256 * 100
    localparam int                DUTY_SHIFT    = 8;
    localparam logic [VAL_W-1:0]  DUTY_DIVISOR  = 24'd100;

    localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LEVEL  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DUTY   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FREQ   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PERIOD = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

    typedef struct packed {
        logic load;
        logic tick;
        logic set_level;
        logic set_frac;
        logic div_freq;
        logic per_from_val;
        logic per_from_div;
        logic mul;
        logic mul_new;
        logic scale;
        logic duty_commit;
        logic period_commit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic ch_ok;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: src/mpp_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on nothing outside this file
module mpp_div #(
    parameter int DVD_W = 31,
    parameter int DVS_W = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient,
    output logic             o_done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W:0]   r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           fits;

    always_comb begin
        shifted = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
        fits    = shifted >= {1'b0, r_dvs};
        diff    = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff : shifted;
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// File: src/mpp_datapath.sv
// per-channel pwm state, tick update, duty scaling and output register
// depends on mpp_pkg and mpp_div
module mpp_datapath
    import mpp_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [RATE_W-1:0]     i_cfg_data,
    input  logic [CH_FIELD_W-1:0] i_channel,
    input  logic [VAL_W-1:0]      i_value,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    output logic [PORT_W-1:0]     o_port_word,
    output logic                  o_pin_level,
    output logic [FRAC_W-1:0]     o_duty_readback
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = COUNT_BITS + FRAC_W;
    localparam int SCL_W  = PROD_W - DUTY_SHIFT;
    localparam int DIV_W  = (SCL_W > VAL_W) ? SCL_W : VAL_W;
    localparam logic [CH_FIELD_W:0] CH_LIMIT = (CH_FIELD_W + 1)'(CHANNELS);
    // reciprocal of the duty divisor, exact for every SCL_W-bit operand
    localparam int RCP_SH = SCL_W + $clog2(DUTY_DIVISOR);
    localparam int RCP_W  = 2 * SCL_W + 1;
    localparam logic [SCL_W:0] DUTY_RECIP = (SCL_W + 1)'(
        ((64'd1 << RCP_SH) + 64'(DUTY_DIVISOR) - 64'd1) / 64'(DUTY_DIVISOR));

    logic [RATE_W-1:0]     r_tick_rate;
    logic [COUNT_BITS-1:0] r_counter [CHANNELS];
    logic [COUNT_BITS-1:0] r_period  [CHANNELS];
    logic [COUNT_BITS-1:0] r_duty    [CHANNELS];
    logic [FRAC_W-1:0]     r_frac    [CHANNELS];
    logic [CHANNELS-1:0]   r_port;

    logic [CH_W-1:0]       r_ch;
    logic                  r_ch_ok;
    logic [COUNT_BITS-1:0] r_per;
    logic [PROD_W-1:0]     r_prod;
    logic [RCP_W-1:0]      r_scl;

    logic                  r_out_valid;
    logic [PORT_W-1:0]     r_out_word;
    logic                  r_out_pin;
    logic [FRAC_W-1:0]     r_out_duty;

    logic [COUNT_BITS-1:0] n_cnt [CHANNELS];
    logic [CH_W-1:0]       ich;
    logic [FRAC_W-1:0]     frac_clamped;
    logic [COUNT_BITS-1:0] mul_per;
    logic [DIV_W-1:0]      div_dividend;
    logic [VAL_W-1:0]      div_divisor;
    logic [DIV_W-1:0]      div_quo;
    logic                  div_done;
    logic [COUNT_BITS-1:0] duty_t;
    logic                  out_free;

    function automatic logic [COUNT_BITS-1:0] sat_count(input logic [DIV_W-1:0] v);
        logic [COUNT_BITS-1:0] res;
        if (|v[DIV_W-1:COUNT_BITS]) begin
            res = '1;
        end else begin
            res = v[COUNT_BITS-1:0];
        end
        return res;
    endfunction

    // tick: every running channel advances and wraps at its period
    always_comb begin
        for (int p = 0; p < CHANNELS; p++) begin
            n_cnt[p] = r_counter[p] + COUNT_BITS'(1);
            if (n_cnt[p] >= r_period[p]) begin
                n_cnt[p] = '0;
            end
        end
    end

    always_comb begin
        ich          = i_channel[CH_W-1:0];
        frac_clamped = (i_value > VAL_W'(FULL_DUTY)) ? FULL_DUTY : i_value[FRAC_W-1:0];
        mul_per      = i_cmd.mul_new ? r_per : r_period[r_ch];
        div_dividend = DIV_W'(r_tick_rate);
        div_divisor  = (i_value == '0) ? VAL_W'(1) : i_value;
        duty_t       = r_scl[RCP_SH +: COUNT_BITS];
        out_free     = !r_out_valid || i_out_ready;
    end

    mpp_div #(
        .DVD_W (DIV_W),
        .DVS_W (VAL_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_freq),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= RATE_RESET;
            r_port      <= '0;
            for (int p = 0; p < CHANNELS; p++) begin
                r_counter[p] <= '0;
                r_period[p]  <= COUNT_BITS'(PERIOD_RESET);
                r_duty[p]    <= '0;
                r_frac[p]    <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_tick_rate <= i_cfg_data;
            end
            if (i_cmd.tick) begin
                for (int p = 0; p < CHANNELS; p++) begin
                    if (r_period[p] != '0) begin
                        r_counter[p] <= n_cnt[p];
                        r_port[p]    <= n_cnt[p] < r_duty[p];
                    end
                end
            end
            if (i_cmd.set_level) begin
                r_period[ich] <= '0;
                r_port[ich]   <= i_value[0];
            end
            if (i_cmd.set_frac) begin
                r_frac[ich] <= frac_clamped;
            end
            if (i_cmd.duty_commit) begin
                if (duty_t >= r_period[r_ch]) begin
                    // full duty goes static high
                    r_period[r_ch] <= '0;
                    r_port[r_ch]   <= 1'b1;
                end else begin
                    r_duty[r_ch] <= duty_t;
                end
            end
            if (i_cmd.period_commit) begin
                r_period[r_ch]  <= r_per;
                r_duty[r_ch]    <= duty_t;
                r_counter[r_ch] <= '0;
            end
        end
    end

    // item latches and scaling operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch    <= ich;
            r_ch_ok <= o_status.ch_ok;
        end
        if (i_cmd.per_from_val) begin
            r_per <= sat_count(DIV_W'(i_value));
        end else if (i_cmd.per_from_div) begin
            r_per <= (div_quo == '0) ? COUNT_BITS'(1) : sat_count(div_quo);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(mul_per) * PROD_W'(r_frac[r_ch]);
        end
        // divide by 25600: drop 8 bits, then multiply by the reciprocal of 100
        if (i_cmd.scale) begin
            r_scl <= RCP_W'(r_prod[PROD_W-1:DUTY_SHIFT]) * RCP_W'(DUTY_RECIP);
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word <= PORT_W'(r_port);
            r_out_pin  <= r_ch_ok && r_port[r_ch];
            r_out_duty <= r_ch_ok ? r_frac[r_ch] : '0;
        end
    end

    assign o_status.ch_ok    = {1'b0, i_channel} < CH_LIMIT;
    assign o_status.div_done = div_done;
    assign o_status.out_free = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_port_word     = r_out_word;
    assign o_pin_level     = r_out_pin;
    assign o_duty_readback = r_out_duty;

endmodule

// File: src/mpp_ctrl.sv
// sequencing state machine for the multichannel pwm port
// depends on mpp_pkg; drives the datapath through t_cmd
module mpp_ctrl
    import mpp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [ACT_W-1:0] i_action,
    input  t_status          i_status,
    output logic             o_in_ready,
    output t_cmd             o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_COMMIT,
        S_FWAIT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_new_per, n_new_per;
    logic   r_in_ready, n_in_ready;
    t_cmd   cmd;

    always_comb begin
        n_state   = r_state;
        n_new_per = r_new_per;
        cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DONE;
                    unique case (i_action)
                        ACT_TICK: begin
                            cmd.tick = 1'b1;
                        end
                        ACT_LEVEL: begin
                            cmd.set_level = i_status.ch_ok;
                        end
                        ACT_DUTY: begin
                            if (i_status.ch_ok) begin
                                cmd.set_frac = 1'b1;
                                n_new_per    = 1'b0;
                                n_state      = S_MUL;
                            end
                        end
                        ACT_FREQ: begin
                            if (i_status.ch_ok) begin
                                cmd.div_freq = 1'b1;
                                n_new_per    = 1'b1;
                                n_state      = S_FWAIT;
                            end
                        end
                        ACT_PERIOD: begin
                            if (i_status.ch_ok) begin
                                cmd.per_from_val = 1'b1;
                                n_new_per        = 1'b1;
                                n_state          = S_MUL;
                            end
                        end
                        default: begin
                            // read pin and unused codes change nothing
                        end
                    endcase
                end
            end
            S_FWAIT: begin
                if (i_status.div_done) begin
                    cmd.per_from_div = 1'b1;
                    n_state          = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul     = 1'b1;
                cmd.mul_new = r_new_per;
                n_state     = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale = 1'b1;
                n_state   = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.period_commit = r_new_per;
                cmd.duty_commit   = !r_new_per;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_new_per  <= 1'b0;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_new_per  <= n_new_per;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = cmd;

endmodule

// File: src/multichannel_pwm_port.sv
// top level of the multichannel pwm port
// depends on mpp_pkg, mpp_ctrl, mpp_datapath and mpp_div
//
// Up to 32 pwm channels drive one 32-bit port word, bit n for channel n. Each
// input word is one action (tick, static level, duty, frequency, period, read)
// and gives exactly one output word with the port bits, the addressed pin and
// its stored duty. Tick, static level, read and unused actions are accepted
// and then loaded into the output register. Duty and period writes go through
// accept, period times duty, a reciprocal multiply for the division by 25600,
// commit, then the output load. A frequency write first runs the bit-serial
// divider for tick_rate / frequency, with DIV_W = max(24, COUNT_BITS + 7)
// bits (31 at the default widths) and one quotient bit per cycle, then takes
// the steps of a period write. The next word is taken while a result still
// waits in the output register. The tick rate register is written through
// the cfg port, which is always ready.
module multichannel_pwm_port
    import mpp_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [RATE_W-1:0]     i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [CH_FIELD_W-1:0] i_channel,
    input  logic [VAL_W-1:0]      i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PORT_W-1:0]     o_port_word,
    output logic                  o_pin_level,
    output logic [FRAC_W-1:0]     o_duty_readback
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    mpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    mpp_datapath #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_channel       (i_channel),
        .i_value         (i_value),
        .i_out_ready     (i_out_ready),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_port_word     (o_port_word),
        .o_pin_level     (o_pin_level),
        .o_duty_readback (o_duty_readback)
    );

endmodule
